// File: src/rnst_pkg.sv
// Shared types and constants for the RTP NACK sequence tracker.
// No dependencies; every other file imports this package.
`default_nettype none

package rnst_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int PTR_W    = IDX_W + 1;

   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(CAPACITY - 1);
   localparam logic [PTR_W-1:0] SLOT_COUNT = PTR_W'(CAPACITY);

   typedef enum logic [2:0] {
      F_ARRIVAL     = 3'd0,
      F_STORE       = 3'd1,
      F_REMOVE      = 3'd2,
      F_READ        = 3'd3,
      F_CLEAR_OLDER = 3'd4,
      F_FULL_RESET  = 3'd5,
      F_DROP        = 3'd6
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SWEEP  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic             load;        // latch the incoming request
      logic             rd_req;      // read slot at incoming seq
      logic             rd_sweep;    // read slot at sweep_addr
      logic             wr_zero;     // write empty word at sweep_addr
      logic             chk;         // test read data, clear chk_addr if older
      logic [IDX_W-1:0] sweep_addr;
      logic [IDX_W-1:0] chk_addr;
      logic             commit;      // apply request, load result register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// File: src/rtp_nack_sequence_tracker_top.sv
// RTP NACK sequence tracker, top level. A request accepted in idle has its result loaded
// into the output register at commit, which waits while that register is occupied;
// arrival, store, remove, read, drop go accept, then commit via the slot memory's read port.
// Clear older first sweeps every slot (one slot read and tested per cycle, plus the last
// test and the pipeline drain), full reset first clears every slot (one slot cleared per cycle).
// After reset a clearing pass empties the slot memory with req_tready low.
// Reset is synchronous, active high. Depends on rnst_pkg, rnst_ctrl, rnst_dp.
`default_nettype none

module rtp_nack_sequence_tracker_top
   import rnst_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,

   // request channel
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [2:0]    req_tuser,   // [2:0] func
   input  wire logic [31:0]   req_tdata,   // [15:0] seq, [31:16] value

   // result channel
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [1:0]         rsp_tuser,   // [0] range_valid, [1] slot_valid
   output logic [103:0]       rsp_tdata    // [0] status, [16:1] miss_first,
                                           // [32:17] miss_last, [48:33] slot_value,
                                           // [80:49] extended_highest,
                                           // [96:81] window_size, [97] is_empty, rest 0
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   // Controller: owns the FSM and the slot sweep pointer. A request is taken only in
   // idle; the result register lets the next request in while a result waits.
   rnst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: window begin/end, wrap count, slot memory of {present, value} words and
   // the result register. The slot read is issued on accept and consumed at commit.
   rnst_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: src/rnst_ctrl.sv
// Controller FSM for the RTP NACK sequence tracker: request intake, slot sweeps, commit.
// Depends on rnst_pkg.
`default_nettype none

module rnst_ctrl
   import rnst_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [2:0]   req_func,
   input  wire dp_sts_type   sts,
   output ctrl_cmd_type      cmd
);

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             mode_all_ff, mode_all_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      mode_all_in  = mode_all_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.sweep_addr = ptr_ff[IDX_W-1:0];
      cmd.chk_addr   = pend_addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_zero = 1'b1;
            ptr_in      = ptr_ff + PTR_W'(1);
            if (ptr_ff == LAST_SLOT) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load   = 1'b1;
               cmd.rd_req = 1'b1;
               ptr_in     = '0;
               priority if (req_func == F_CLEAR_OLDER) begin
                  mode_all_in = 1'b0;
                  state_in    = ST_SWEEP;
               end else if (req_func == F_FULL_RESET) begin
                  mode_all_in = 1'b1;
                  state_in    = ST_SWEEP;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_SWEEP: begin
            if (mode_all_ff) begin
               cmd.wr_zero = 1'b1;
               ptr_in      = ptr_ff + PTR_W'(1);
               if (ptr_ff == LAST_SLOT) begin
                  state_in = ST_COMMIT;
               end
            end else begin
               // read slot ptr, test the previously read slot at pend_addr
               cmd.chk      = pend_ff;
               pend_addr_in = ptr_ff[IDX_W-1:0];
               if (ptr_ff != SLOT_COUNT) begin
                  cmd.rd_sweep = 1'b1;
                  pend_in      = 1'b1;
                  ptr_in       = ptr_ff + PTR_W'(1);
               end else if (!pend_ff) begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         ptr_ff      <= '0;
         mode_all_ff <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ptr_ff      <= ptr_in;
         mode_all_ff <= mode_all_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
   end

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("commit while result register is occupied");

   a_commit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after commit");

   a_clear_all_no_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && mode_all_ff) |-> !pend_ff)
      else $error("pending slot check during clear-all sweep");

endmodule

`default_nettype wire

// File: src/rnst_dp.sv
// Datapath for the RTP NACK sequence tracker: window registers, slot memory, result register.
// Depends on rnst_pkg; driven by rnst_ctrl commands.
`default_nettype none

module rnst_dp
   import rnst_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output dp_sts_type         sts,
   input  wire logic [2:0]    req_tuser,
   input  wire logic [31:0]   req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [1:0]         rsp_tuser,
   output logic [103:0]       rsp_tdata
);

   typedef struct packed {
      logic        present;
      logic [15:0] data;
   } slot_type;

   // latched request
   func_type    func_ff;
   logic [15:0] seq_ff;
   logic [15:0] value_ff;

   // window state
   logic        started_ff, started_in;
   logic [15:0] win_begin_ff, win_begin_in;
   logic [15:0] win_end_ff, win_end_in;
   logic [15:0] wrap_ff, wrap_in;     // wrap count, upper half of extended_highest

   // slot memory
   slot_type         mem [CAPACITY];
   slot_type         rd_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_type         wr_word;

   // result
   logic        status_in, rvalid_in, svalid_in;
   logic [15:0] first_in, last_in, sval_in;
   logic [15:0] fwd_d, back_d;
   logic [31:0] ext_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        status_ff, rvalid_ff, svalid_ff, empty_ff;
   logic [15:0] first_ff, last_ff, sval_ff, wsize_ff;
   logic [31:0] ext_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= func_type'(req_tuser);
         seq_ff   <= req_tdata[15:0];
         value_ff <= req_tdata[31:16];
      end
   end

   // ---- slot memory ----
   assign rd_en   = cmd.rd_req || cmd.rd_sweep;
   assign rd_addr = cmd.rd_sweep ? cmd.sweep_addr : req_tdata[IDX_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = seq_ff[IDX_W-1:0];
      wr_word = '0;
      priority if (cmd.wr_zero) begin
         wr_en   = 1'b1;
         wr_addr = cmd.sweep_addr;
      end else if (cmd.chk && rd_ff.present && (rd_ff.data < seq_ff)) begin
         wr_en   = 1'b1;
         wr_addr = cmd.chk_addr;
      end else if (cmd.commit && func_ff == F_STORE) begin
         wr_en   = 1'b1;
         wr_word = '{present: 1'b1, data: value_ff};
      end else if (cmd.commit && (func_ff == F_REMOVE || func_ff == F_DROP)) begin
         wr_en   = 1'b1;
      end else begin
         wr_en   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // ---- window update and result ----
   assign fwd_d  = seq_ff - win_end_ff;
   assign back_d = win_begin_ff - seq_ff;

   always_comb begin
      started_in   = started_ff;
      win_begin_in = win_begin_ff;
      win_end_in   = win_end_ff;
      wrap_in      = wrap_ff;
      status_in    = 1'b0;
      rvalid_in    = 1'b0;
      first_in     = '0;
      last_in      = '0;
      svalid_in    = 1'b0;
      sval_in      = '0;
      unique case (func_ff)
         F_ARRIVAL: begin
            if (!started_ff) begin
               started_in   = 1'b1;
               win_begin_in = seq_ff;
               win_end_in   = seq_ff + 16'd1;
            end else if (!fwd_d[15]) begin
               rvalid_in  = 1'b1;
               first_in   = win_end_ff;
               last_in    = seq_ff;
               if (seq_ff < win_end_ff) begin
                  wrap_in = wrap_ff + 16'd1;
               end
               win_end_in = seq_ff + 16'd1;
            end else begin
               status_in = 1'b1;
               if (!back_d[15] && back_d != 16'd0) begin
                  rvalid_in    = 1'b1;
                  first_in     = seq_ff;
                  last_in      = win_begin_ff;
                  win_begin_in = seq_ff;
               end
            end
         end
         F_READ: begin
            svalid_in = rd_ff.present;
            sval_in   = rd_ff.present ? rd_ff.data : 16'd0;
         end
         F_FULL_RESET: begin
            started_in   = 1'b0;
            win_begin_in = '0;
            win_end_in   = '0;
         end
         F_DROP: begin
            win_begin_in = seq_ff + 16'd1;
         end
         default: begin
            started_in = started_ff;
         end
      endcase
   end

   assign ext_in = {wrap_in, win_end_in} - 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         win_begin_ff <= '0;
         win_end_ff   <= '0;
         wrap_ff      <= '0;
      end else if (cmd.commit) begin
         started_ff   <= started_in;
         win_begin_ff <= win_begin_in;
         win_end_ff   <= win_end_in;
         wrap_ff      <= wrap_in;
      end
   end

   // ---- result register ----
   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         rvalid_ff <= rvalid_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         sval_ff   <= sval_in;
         svalid_ff <= svalid_in;
         ext_ff    <= ext_in;
         wsize_ff  <= win_end_in - win_begin_in;
         empty_ff  <= (win_begin_in == win_end_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {svalid_ff, rvalid_ff};
   assign rsp_tdata  = {6'd0, empty_ff, wsize_ff, ext_ff, sval_ff, last_ff, first_ff,
                        status_ff};

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_no_sweep_on_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_zero && cmd.commit))
      else $error("sweep write collides with commit");

   a_arrival_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && func_ff == F_ARRIVAL) |=> started_ff)
      else $error("arrival left tracker unstarted");

endmodule

`default_nettype wire
